@@ rtl/spc_pkg.sv @@
package spc_pkg;

    // start code values that follow the 00 00 01 prefix
    localparam logic [7:0] SC_PREFIX_END = 8'h01;
    localparam logic [7:0] SC_PACK       = 8'hBA;
    localparam logic [7:0] SC_SYSTEM     = 8'hBB;
    localparam logic [7:0] SC_SEQ_HDR    = 8'hB3;
    localparam logic [7:0] SC_GOP        = 8'hB8;
    localparam logic [7:0] SC_PICTURE    = 8'h00;
    localparam logic [7:0] SC_VIDEO_LO   = 8'hE0;
    localparam logic [7:0] SC_VIDEO_HI   = 8'hEF;
    localparam logic [7:0] SC_AUDIO_LO   = 8'hC0;
    localparam logic [7:0] SC_AUDIO_HI   = 8'hDF;
    localparam logic [7:0] SC_SLICE_LO   = 8'h01;
    localparam logic [7:0] SC_SLICE_HI   = 8'hAF;

    localparam logic [3:0] RATE_LO = 4'd1;
    localparam logic [3:0] RATE_HI = 4'd8;
    localparam logic [2:0] PTYPE_LO = 3'd1;
    localparam logic [2:0] PTYPE_HI = 3'd3;

    // bytes after the id: sequence header takes 4, picture header takes 2
    localparam logic [1:0] SEQ_LAST = 2'd3;
    localparam logic [1:0] WIN_FULL = 2'd2;

    typedef enum logic [3:0] {
        KIND_PACK    = 4'd0,
        KIND_SYSTEM  = 4'd1,
        KIND_SEQ_HDR = 4'd2,
        KIND_GOP     = 4'd3,
        KIND_PICTURE = 4'd4,
        KIND_VIDEO   = 4'd5,
        KIND_AUDIO   = 4'd6,
        KIND_SLICE   = 4'd7,
        KIND_UNIMPL  = 4'd8
    } t_kind;

    typedef enum logic [3:0] {
        PH_SCAN = 4'b0001,
        PH_ID   = 4'b0010,
        PH_SEQ  = 4'b0100,
        PH_PIC  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [3:0]  code_kind;
        logic [7:0]  stream_id;
        logic [11:0] frame_width;
        logic [11:0] frame_height;
        logic [3:0]  rate_code;
        logic        rate_known;
        logic [2:0]  picture_type;
        logic        picture_type_known;
    } t_result;

    function automatic t_kind classify(input logic [7:0] id);
        t_kind k;
        if (id == SC_PACK)
            k = KIND_PACK;
        else if (id == SC_SYSTEM)
            k = KIND_SYSTEM;
        else if (id == SC_SEQ_HDR)
            k = KIND_SEQ_HDR;
        else if (id == SC_GOP)
            k = KIND_GOP;
        else if (id == SC_PICTURE)
            k = KIND_PICTURE;
        else if (id >= SC_VIDEO_LO && id <= SC_VIDEO_HI)
            k = KIND_VIDEO;
        else if (id >= SC_AUDIO_LO && id <= SC_AUDIO_HI)
            k = KIND_AUDIO;
        else if (id >= SC_SLICE_LO && id <= SC_SLICE_HI)
            k = KIND_SLICE;
        else
            k = KIND_UNIMPL;
        return k;
    endfunction

endpackage

@@ rtl/spc_byte_if.sv @@
interface spc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

@@ rtl/spc_result_if.sv @@
interface spc_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  code_kind;
    logic [7:0]  stream_id;
    logic [11:0] frame_width;
    logic [11:0] frame_height;
    logic [3:0]  rate_code;
    logic        rate_known;
    logic [2:0]  picture_type;
    logic        picture_type_known;

    modport source (
        output valid, output code_kind, output stream_id, output frame_width,
        output frame_height, output rate_code, output rate_known,
        output picture_type, output picture_type_known, input ready
    );
    modport sink (
        input valid, input code_kind, input stream_id, input frame_width,
        input frame_height, input rate_code, input rate_known,
        input picture_type, input picture_type_known, output ready
    );
endinterface

@@ rtl/spc_in_reg.sv @@
module spc_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spc_byte_if.sink   i_byte,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_byte
);
    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic       w_take;

    // refill whenever the register is empty or the held word moves on this cycle
    assign i_byte.ready = !r_valid || i_advance;
    assign w_take       = i_byte.valid && i_byte.ready;

    always_comb begin
        n_valid = r_valid;
        if (w_take)
            n_valid = 1'b1;
        else if (i_advance)
            n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte <= i_byte.data_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
endmodule

@@ rtl/spc_parser.sv @@
module spc_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic [7:0]      i_byte,
    output logic            o_has_result,
    output spc_pkg::t_result o_result
);
    import spc_pkg::*;

    t_phase      r_phase;
    t_phase      n_phase;
    logic [15:0] r_recent;
    logic [15:0] n_recent;
    logic [1:0]  r_fill;
    logic [1:0]  n_fill;
    logic [23:0] r_held;
    logic [23:0] n_held;
    logic [1:0]  r_hcount;
    logic [1:0]  n_hcount;
    logic [3:0]  w_rate;
    logic [2:0]  w_ptype;

    assign w_rate  = i_byte[3:0];
    assign w_ptype = i_byte[5:3];

    always_comb begin
        n_phase      = r_phase;
        n_recent     = r_recent;
        n_fill       = r_fill;
        n_held       = r_held;
        n_hcount     = r_hcount;
        o_has_result = 1'b0;
        o_result     = '0;
        case (r_phase)
            PH_ID: begin
                if (i_byte == SC_SEQ_HDR) begin
                    n_phase  = PH_SEQ;
                    n_held   = '0;
                    n_hcount = '0;
                end else if (i_byte == SC_PICTURE) begin
                    n_phase  = PH_PIC;
                    n_held   = '0;
                    n_hcount = '0;
                end else begin
                    o_has_result       = 1'b1;
                    o_result.code_kind = classify(i_byte);
                    o_result.stream_id = i_byte;
                end
            end
            PH_SEQ: begin
                if (r_hcount != SEQ_LAST) begin
                    n_held   = {r_held[15:0], i_byte};
                    n_hcount = r_hcount + 2'd1;
                end else begin
                    o_has_result          = 1'b1;
                    o_result.code_kind    = KIND_SEQ_HDR;
                    o_result.stream_id    = SC_SEQ_HDR;
                    o_result.frame_width  = r_held[23:12];
                    o_result.frame_height = r_held[11:0];
                    o_result.rate_code    = w_rate;
                    o_result.rate_known   = (w_rate >= RATE_LO) && (w_rate <= RATE_HI);
                end
            end
            PH_PIC: begin
                // first picture header byte carries nothing we report
                if (r_hcount == 2'd0) begin
                    n_hcount = 2'd1;
                end else begin
                    o_has_result                = 1'b1;
                    o_result.code_kind          = KIND_PICTURE;
                    o_result.stream_id          = SC_PICTURE;
                    o_result.picture_type       = w_ptype;
                    o_result.picture_type_known = (w_ptype >= PTYPE_LO)
                                                  && (w_ptype <= PTYPE_HI);
                end
            end
            default: begin
                n_phase = PH_SCAN;
                if (r_fill == WIN_FULL && r_recent == 16'h0000 && i_byte == SC_PREFIX_END) begin
                    n_phase  = PH_ID;
                    n_fill   = '0;
                    n_recent = '0;
                end else begin
                    n_recent = {r_recent[7:0], i_byte};
                    n_fill   = (r_fill == WIN_FULL) ? WIN_FULL : r_fill + 2'd1;
                end
            end
        endcase
        // a finished start code empties the window and header store
        if (o_has_result) begin
            n_phase  = PH_SCAN;
            n_fill   = '0;
            n_recent = '0;
            n_held   = '0;
            n_hcount = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SCAN;
            r_recent <= '0;
            r_fill   <= '0;
            r_held   <= '0;
            r_hcount <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_recent <= n_recent;
            r_fill   <= n_fill;
            r_held   <= n_held;
            r_hcount <= n_hcount;
        end
    end

`ifndef SYNTH
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill != 2'd3)
        else $error("window fill out of range");

    a_result_rescans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_has_result) |=> (r_phase == PH_SCAN && r_fill == 2'd0
                                      && r_hcount == 2'd0))
        else $error("parser did not return to scanning after a result");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> ($stable(r_phase) && $stable(r_fill) && $stable(r_hcount)))
        else $error("parser state moved without a word");

    a_window_empty_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_SCAN) |-> (r_fill == 2'd0 && r_recent == 16'h0000))
        else $error("window not empty while parsing a header");
`endif
endmodule

@@ rtl/spc_out_reg.sv @@
module spc_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  spc_pkg::t_result i_result,
    output logic             o_busy,
    spc_result_if.source     o_result
);
    import spc_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_data;

    always_comb begin
        n_valid = r_valid;
        if (i_load)
            n_valid = 1'b1;
        else if (o_result.ready)
            n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_result;
        end
    end

    // a held word that is not taken this cycle blocks the parser
    assign o_busy = r_valid && !o_result.ready;

    assign o_result.valid              = r_valid;
    assign o_result.code_kind          = r_data.code_kind;
    assign o_result.stream_id          = r_data.stream_id;
    assign o_result.frame_width        = r_data.frame_width;
    assign o_result.frame_height       = r_data.frame_height;
    assign o_result.rate_code          = r_data.rate_code;
    assign o_result.rate_known         = r_data.rate_known;
    assign o_result.picture_type       = r_data.picture_type;
    assign o_result.picture_type_known = r_data.picture_type_known;
endmodule

@@ rtl/mpeg_start_code_parser_core.sv @@
// mpeg start code parser
// i_byte: one stream byte per word (valid/ready). o_result: one word per
// start code, with its kind, id, sequence header sizes and rate code, or
// the picture coding type, plus flags for known rate and picture type.
// a word goes to o_result on the byte that completes the start code: the
// id byte for most codes, the fourth header byte for a sequence header, the
// second header byte for a picture header; other bytes give nothing.
// a byte accepted into the input register is parsed once the result register
// is not blocked; its result is then loaded into the result register and
// shown as valid on o_result.
// throughput: one byte per cycle while o_result does not hold a word back,
// set by the single parse stage between the input and result registers.
// reset (i_rst_n low at a clock edge) empties both registers and puts the
// parser back to scanning with an empty two-byte window.
// when o_result.ready is low with a word held, the parser stops and the
// input register keeps its byte; an empty input register still takes one
// byte, then i_byte.ready stays low until the held word is taken.
module mpeg_start_code_parser_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    spc_byte_if.sink     i_byte,
    spc_result_if.source o_result
);
    import spc_pkg::*;

    logic       w_in_valid;
    logic [7:0] w_in_byte;
    logic       w_out_busy;
    logic       w_advance;
    logic       w_has_result;
    t_result    w_result;

    assign w_advance = w_in_valid && !w_out_busy;

    spc_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (i_byte),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_byte    (w_in_byte)
    );

    spc_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_advance),
        .i_byte       (w_in_byte),
        .o_has_result (w_has_result),
        .o_result     (w_result)
    );

    spc_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance && w_has_result),
        .i_result (w_result),
        .o_busy   (w_out_busy),
        .o_result (o_result)
    );
endmodule

@@ tb/sv/testbench.sv @@
module testbench;
    import spc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_BYTES = 1000;
    localparam logic [7:0] PREFIX_ZERO = 8'h00;

    logic clk;
    logic rst_n;

    spc_byte_if   byte_ch();
    spc_result_if res_ch();

    mpeg_start_code_parser_core uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_byte  (byte_ch),
        .o_result(res_ch)
    );

    // parser state as the block should hold it
    logic [15:0] win_bytes;
    logic [1:0]  win_count;
    t_phase      phase;
    logic [23:0] hdr_bytes;
    logic [2:0]  hdr_count;

    t_result pending_codes[$];
    int      mismatch_count = 0;
    int      bytes_sent = 0;
    int      cycle_count = 0;
    int      hold_cycles = 0;
    bit      tx_steady = 0;
    bit      rx_steady = 0;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    function automatic t_kind kind_of(input logic [7:0] id);
        t_kind k;
        k = KIND_UNIMPL;
        if (id >= SC_SLICE_LO && id <= SC_SLICE_HI)
            k = KIND_SLICE;
        if (id >= SC_AUDIO_LO && id <= SC_AUDIO_HI)
            k = KIND_AUDIO;
        if (id >= SC_VIDEO_LO && id <= SC_VIDEO_HI)
            k = KIND_VIDEO;
        case (id)
            SC_PACK:    k = KIND_PACK;
            SC_SYSTEM:  k = KIND_SYSTEM;
            SC_SEQ_HDR: k = KIND_SEQ_HDR;
            SC_GOP:     k = KIND_GOP;
            SC_PICTURE: k = KIND_PICTURE;
            default:    ;
        endcase
        return k;
    endfunction

    task rescan();
        phase = PH_SCAN;
        win_bytes = '0;
        win_count = '0;
        hdr_bytes = '0;
        hdr_count = '0;
    endtask

    // advance the parser by one byte, queue the start code it completes
    task parse_byte(input logic [7:0] b);
        t_result r;
        r = '0;
        case (phase)
            PH_ID: begin
                if (b == SC_SEQ_HDR || b == SC_PICTURE) begin
                    phase = (b == SC_SEQ_HDR) ? PH_SEQ : PH_PIC;
                    hdr_bytes = '0;
                    hdr_count = '0;
                end else begin
                    r.code_kind = kind_of(b);
                    r.stream_id = b;
                    pending_codes.push_back(r);
                    rescan();
                end
            end
            PH_SEQ: begin
                if (hdr_count < 3) begin
                    hdr_bytes = {hdr_bytes[15:0], b};
                    hdr_count++;
                end else begin
                    r.code_kind = KIND_SEQ_HDR;
                    r.stream_id = SC_SEQ_HDR;
                    r.frame_width = {hdr_bytes[23:16], hdr_bytes[15:12]};
                    r.frame_height = {hdr_bytes[11:8], hdr_bytes[7:0]};
                    r.rate_code = b[3:0];
                    r.rate_known = (b[3:0] >= RATE_LO && b[3:0] <= RATE_HI);
                    pending_codes.push_back(r);
                    rescan();
                end
            end
            PH_PIC: begin
                if (hdr_count == 0) begin
                    hdr_bytes = {16'h0, b};
                    hdr_count = 1;
                end else begin
                    r.code_kind = KIND_PICTURE;
                    r.stream_id = SC_PICTURE;
                    r.picture_type = b[5:3];
                    r.picture_type_known = (b[5:3] >= PTYPE_LO && b[5:3] <= PTYPE_HI);
                    pending_codes.push_back(r);
                    rescan();
                end
            end
            default: begin
                phase = PH_SCAN;
                if (win_count == 2 && win_bytes == 16'h0 && b == SC_PREFIX_END) begin
                    phase = PH_ID;
                    win_bytes = '0;
                    win_count = '0;
                end else begin
                    win_bytes = {win_bytes[7:0], b};
                    if (win_count < 2)
                        win_count++;
                end
            end
        endcase
    endtask

    // one byte word: optional gap, then hold valid until it is taken
    task send_byte(input logic [7:0] b);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 7);
        repeat (gap) begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= b;
        do @(posedge clk); while (!byte_ch.ready);
        parse_byte(b);
        bytes_sent++;
    endtask

    // prefix, id and the header bytes the id calls for, first byte in hdr[31:24]
    task send_code(input logic [7:0] id, input logic [31:0] hdr);
        send_byte(PREFIX_ZERO);
        send_byte(PREFIX_ZERO);
        send_byte(SC_PREFIX_END);
        send_byte(id);
        if (id == SC_SEQ_HDR) begin
            for (int i = 3; i >= 0; i--)
                send_byte(hdr[i*8 +: 8]);
        end else if (id == SC_PICTURE) begin
            send_byte(hdr[31:24]);
            send_byte(hdr[23:16]);
        end
    endtask

    function automatic logic [7:0] random_id();
        logic [7:0] id;
        case ($urandom_range(0, 8))
            0: id = SC_PACK;
            1: id = SC_SYSTEM;
            2: id = SC_SEQ_HDR;
            3: id = SC_GOP;
            4: id = SC_PICTURE;
            5: id = 8'($urandom_range(SC_VIDEO_LO, SC_VIDEO_HI));
            6: id = 8'($urandom_range(SC_AUDIO_LO, SC_AUDIO_HI));
            7: id = 8'($urandom_range(SC_SLICE_LO, SC_SLICE_HI));
            default: begin
                do id = 8'($urandom_range(8'hB0, 8'hFF));
                while (kind_of(id) != KIND_UNIMPL);
            end
        endcase
        return id;
    endfunction

    function automatic logic [31:0] random_header();
        logic [31:0] h;
        case ($urandom_range(0, 7))
            0: h = 32'hFFFF_FFFF;
            1: h = 32'h0;
            2: h = {24'h00_0001, 8'($urandom)};
            3: h = {8'h00, 8'h01, 16'($urandom)};
            default: h = $urandom;
        endcase
        return h;
    endfunction

    // receiver: random stall per word, plus long hold-offs on request
    initial begin
        int stall;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_cycles > 0) begin
                res_ch.ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            if ($urandom_range(0, 15) == 0)
                rx_steady = !rx_steady;
            stall = rx_steady ? 0 : $urandom_range(0, 7);
            repeat (stall) begin
                res_ch.ready <= 1'b0;
                @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid && hold_cycles == 0);
        end
    end

    task check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    always @(posedge clk) begin
        t_result want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_codes.size() == 0) begin
                report_mismatch($sformatf("unexpected word, id 0x%0h", res_ch.stream_id));
            end else begin
                want = pending_codes.pop_front();
                check_field("code_kind", int'(res_ch.code_kind), int'(want.code_kind));
                check_field("stream_id", int'(res_ch.stream_id), int'(want.stream_id));
                check_field("frame_width", int'(res_ch.frame_width),
                            int'(want.frame_width));
                check_field("frame_height", int'(res_ch.frame_height),
                            int'(want.frame_height));
                check_field("rate_code", int'(res_ch.rate_code), int'(want.rate_code));
                check_field("rate_known", int'(res_ch.rate_known),
                            int'(want.rate_known));
                check_field("picture_type", int'(res_ch.picture_type),
                            int'(want.picture_type));
                check_field("picture_type_known", int'(res_ch.picture_type_known),
                            int'(want.picture_type_known));
            end
        end
    end

    task test_code_kinds();
        send_code(SC_PACK, 32'h0);
        send_code(SC_SYSTEM, 32'h0);
        send_code(SC_GOP, 32'h0);
        send_code(SC_VIDEO_LO, 32'h0);
        send_code(SC_VIDEO_HI, 32'h0);
        send_code(SC_AUDIO_LO, 32'h0);
        send_code(SC_AUDIO_HI, 32'h0);
        send_code(SC_SLICE_LO, 32'h0);
        send_code(SC_SLICE_HI, 32'h0);
        send_code(8'hB0, 32'h0);
        send_code(8'hF0, 32'h0);
        send_code(8'hFF, 32'h0);
    endtask

    task test_sequence_header();
        send_code(SC_SEQ_HDR, 32'hFFFF_FFFF);
        send_code(SC_SEQ_HDR, 32'h0000_0000);
        send_code(SC_SEQ_HDR, 32'h1234_5601);
        send_code(SC_SEQ_HDR, 32'hABCD_EF08);
        // prefix inside the header is plain data
        send_code(SC_SEQ_HDR, 32'h0000_0119);
    endtask

    task test_picture_header();
        send_code(SC_PICTURE, {8'hFF, 8'b11_000_111, 16'h0});
        send_code(SC_PICTURE, {8'h00, 8'b00_001_000, 16'h0});
        send_code(SC_PICTURE, {8'h5A, 8'b01_011_101, 16'h0});
        send_code(SC_PICTURE, {8'h00, 8'b10_100_001, 16'h0});
        send_code(SC_PICTURE, {8'hC3, 8'b00_111_000, 16'h0});
    endtask

    task test_window_refill();
        // window is empty after a code: 00 01 alone must not match
        send_code(SC_PACK, 32'h0);
        send_byte(PREFIX_ZERO);
        send_byte(SC_PREFIX_END);
        send_byte(SC_SYSTEM);
        // broken prefix, then a run of zeros before the 01
        send_byte(PREFIX_ZERO);
        send_byte(PREFIX_ZERO);
        send_byte(8'h02);
        send_byte(PREFIX_ZERO);
        send_code(SC_GOP, 32'h0);
    endtask

    task test_backpressure();
        tx_steady = 1;
        hold_cycles = 150;
        repeat (12) send_code(8'($urandom_range(SC_SLICE_LO, SC_SLICE_HI)), 32'h0);
        tx_steady = 0;
    endtask

    task test_random_stream();
        int stop_at;
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 7) == 0)
                tx_steady = !tx_steady;
            case ($urandom_range(0, 15))
                0: repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
                1: begin
                    send_byte(PREFIX_ZERO);
                    if ($urandom_range(0, 1))
                        send_byte(PREFIX_ZERO);
                    send_byte(8'($urandom));
                end
                2: begin
                    repeat ($urandom_range(1, 3)) send_byte(PREFIX_ZERO);
                    send_code(random_id(), random_header());
                end
                default: send_code(random_id(), random_header());
            endcase
        end
        tx_steady = 0;
    endtask

    initial begin
        rst_n <= 1'b0;
        byte_ch.valid <= 1'b0;
        byte_ch.data_byte <= '0;
        rescan();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_code_kinds();
        test_sequence_header();
        test_picture_header();
        test_window_refill();
        test_backpressure();
        test_random_stream();

        byte_ch.valid <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
